[hw/rtl/channel_pending_table_macros.svh]
// Assertion macros for the channel pending table (clock clk, reset rst).
`ifndef CHANNEL_PENDING_TABLE_MACROS_SVH
`define CHANNEL_PENDING_TABLE_MACROS_SVH

// Same-cycle implication.
`define CPT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/cpt_pkg.sv]
// Types and codes shared by the channel pending table.
package cpt_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned TYPE_W   = 8;
  localparam int unsigned TASK_W   = 16;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned TICKS_W  = 32;
  localparam int unsigned STATUS_W = 3;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_CLOSE  = 3'd1;
  localparam logic [OP_W-1:0] OP_SEND   = 3'd2;
  localparam logic [OP_W-1:0] OP_RECV   = 3'd3;
  localparam logic [OP_W-1:0] OP_RETRY  = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WOULD_BLOCK = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SLEEP       = 3'd4;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT     = 3'd5;

  localparam logic [ID_W-1:0]    FIRST_ID      = 32'd1;
  localparam logic [COUNT_W-1:0] PENDING_MAX   = '1;

  // One table entry as stored in the memory
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TYPE_W-1:0]  ctype;
    logic [TASK_W-1:0]  owner;
    logic [TASK_W-1:0]  peer;
    logic [COUNT_W-1:0] pending;
    logic               blocked;
  } entry_t;

endpackage

[hw/rtl/channel_pending_table.sv]
// Channel pending table: entry memory, id scan and read-modify-write sequencer.
//
// A command is taken when start is high and busy is low. Create, unknown
// operations and any lookup on an empty table finish in the dispatch state;
// close, send, receive and retry scan the table one entry per cycle through
// the memory's single read port until the id is found or every live entry
// has been read; close then moves the last entry into the freed slot, and
// send, receive and retry rewrite the found entry in place.
// The result is shown for exactly one cycle with done high, in the cycle in which
// busy falls; the receiver cannot hold it off and must take it then. A new
// command may be started in that same cycle.
`include "channel_pending_table_macros.svh"

module channel_pending_table #(
  parameter int unsigned MAX_CHANNELS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [cpt_pkg::OP_W-1:0]     op,
  input  logic [cpt_pkg::ID_W-1:0]     chan_id,
  input  logic [cpt_pkg::TYPE_W-1:0]   chan_type,
  input  logic [cpt_pkg::TASK_W-1:0]   owner_task,
  input  logic [cpt_pkg::TASK_W-1:0]   peer_task,
  input  logic [cpt_pkg::TICKS_W-1:0]  timeout,
  output logic                         done,
  output logic [cpt_pkg::STATUS_W-1:0] status,
  output logic [cpt_pkg::ID_W-1:0]     new_id,
  output logic                         wake,
  output logic [cpt_pkg::TASK_W-1:0]   wake_task,
  output logic [cpt_pkg::TICKS_W-1:0]  sleep_ticks
);

  localparam int unsigned IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHANNELS);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_SCAN     = 5'b00100,
    S_MOVE     = 5'b01000,
    S_MODIFY   = 5'b10000
  } state_t;

  state_t state;

  // Latched command
  logic [cpt_pkg::OP_W-1:0]    op_q;
  logic [cpt_pkg::ID_W-1:0]    cid_q;
  logic [cpt_pkg::TYPE_W-1:0]  type_q;
  logic [cpt_pkg::TASK_W-1:0]  owner_q;
  logic [cpt_pkg::TASK_W-1:0]  peer_q;
  logic [cpt_pkg::TICKS_W-1:0] tmo_q;

  logic [CNT_W-1:0]          live_count;
  logic [cpt_pkg::ID_W-1:0]  next_id;
  logic [cpt_pkg::ID_W-1:0]  id_inc;
  logic [IDX_W-1:0]          scan_idx;
  logic [IDX_W-1:0]          slot;
  logic [IDX_W-1:0]          last_idx;

  // Entry memory
  cpt_pkg::entry_t mem [MAX_CHANNELS];
  cpt_pkg::entry_t rd_data;
  cpt_pkg::entry_t mem_wdata;
  logic            mem_we;
  logic            mem_re;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;

  logic accept;
  logic full;
  logic lookup_op;
  logic hit;
  logic last_scan;

  // Entry update for send, receive and retry
  cpt_pkg::entry_t                mod_entry;
  logic [cpt_pkg::STATUS_W-1:0]   mod_status;
  logic                           mod_wake;
  logic [cpt_pkg::TASK_W-1:0]     mod_wake_task;
  logic [cpt_pkg::TICKS_W-1:0]    mod_sleep;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign full      = (live_count >= CNT_MAX);
  assign lookup_op = op_q inside {cpt_pkg::OP_CLOSE, cpt_pkg::OP_SEND,
                                  cpt_pkg::OP_RECV, cpt_pkg::OP_RETRY};
  assign hit       = (rd_data.id == cid_q);
  assign last_scan = ((CNT_W'(scan_idx) + CNT_W'(1)) == live_count);
  assign last_idx  = IDX_W'(live_count - CNT_W'(1));
  assign id_inc    = next_id + cpt_pkg::ID_W'(1);

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // Operation on the entry found by the scan
  always_comb begin
    mod_entry     = rd_data;
    mod_status    = cpt_pkg::ST_OK;
    mod_wake      = 1'b0;
    mod_wake_task = '0;
    mod_sleep     = '0;
    case (op_q)
      cpt_pkg::OP_SEND: begin
        if (rd_data.pending != cpt_pkg::PENDING_MAX) begin
          mod_entry.pending = rd_data.pending + cpt_pkg::COUNT_W'(1);
        end
        if (rd_data.blocked) begin
          mod_entry.blocked = 1'b0;
          mod_wake          = 1'b1;
          mod_wake_task     = rd_data.peer;
        end
      end
      cpt_pkg::OP_RECV: begin
        if (rd_data.pending != '0) begin
          mod_entry.pending = rd_data.pending - cpt_pkg::COUNT_W'(1);
        end else if (tmo_q == '0) begin
          mod_status = cpt_pkg::ST_WOULD_BLOCK;
        end else begin
          mod_entry.blocked = 1'b1;
          mod_sleep         = tmo_q;
          mod_status        = cpt_pkg::ST_SLEEP;
        end
      end
      cpt_pkg::OP_RETRY: begin
        if (rd_data.pending == '0) begin
          mod_status = cpt_pkg::ST_TIMEOUT;
        end else begin
          mod_entry.pending = rd_data.pending - cpt_pkg::COUNT_W'(1);
        end
      end
      default: begin
        mod_status = cpt_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // Memory port control per state
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    mem_wdata = rd_data;
    case (state)
      S_DISPATCH: begin
        if (op_q == cpt_pkg::OP_CREATE) begin
          if (!full) begin
            mem_we            = 1'b1;
            mem_waddr         = IDX_W'(live_count);
            mem_wdata.id      = next_id;
            mem_wdata.ctype   = type_q;
            mem_wdata.owner   = owner_q;
            mem_wdata.peer    = peer_q;
            mem_wdata.pending = '0;
            mem_wdata.blocked = 1'b0;
          end
        end else if (lookup_op && live_count != '0) begin
          mem_re = 1'b1;
        end
      end
      S_SCAN: begin
        if (hit && op_q == cpt_pkg::OP_CLOSE) begin
          mem_re    = 1'b1;
          mem_raddr = last_idx;
        end else if (!hit && !last_scan) begin
          mem_re    = 1'b1;
          mem_raddr = scan_idx + IDX_W'(1);
        end
      end
      S_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = slot;
      end
      S_MODIFY: begin
        mem_we    = 1'b1;
        mem_waddr = slot;
        mem_wdata = mod_entry;
      end
      default: begin
      end
    endcase
  end

  // Command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op;
      cid_q   <= chan_id;
      type_q  <= chan_type;
      owner_q <= owner_task;
      peer_q  <= peer_task;
      tmo_q   <= timeout;
    end
  end

  // Sequencer, table counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      live_count  <= '0;
      next_id     <= cpt_pkg::FIRST_ID;
      scan_idx    <= '0;
      slot        <= '0;
      status      <= cpt_pkg::ST_OK;
      new_id      <= '0;
      wake        <= 1'b0;
      wake_task   <= '0;
      sleep_ticks <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          scan_idx <= '0;
          if (mem_re) begin
            state <= S_SCAN;
          end else begin
            state       <= S_IDLE;
            done        <= 1'b1;
            new_id      <= '0;
            wake        <= 1'b0;
            wake_task   <= '0;
            sleep_ticks <= '0;
            status      <= cpt_pkg::ST_NOT_FOUND;
            if (op_q == cpt_pkg::OP_CREATE) begin
              if (full) begin
                status <= cpt_pkg::ST_FULL;
              end else begin
                status     <= cpt_pkg::ST_OK;
                new_id     <= next_id;
                live_count <= live_count + CNT_W'(1);
                next_id    <= (id_inc == '0) ? cpt_pkg::FIRST_ID : id_inc;
              end
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            slot  <= scan_idx;
            state <= (op_q == cpt_pkg::OP_CLOSE) ? S_MOVE : S_MODIFY;
          end else if (last_scan) begin
            state       <= S_IDLE;
            done        <= 1'b1;
            status      <= cpt_pkg::ST_NOT_FOUND;
            new_id      <= '0;
            wake        <= 1'b0;
            wake_task   <= '0;
            sleep_ticks <= '0;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_MOVE: begin
          state       <= S_IDLE;
          done        <= 1'b1;
          live_count  <= live_count - CNT_W'(1);
          status      <= cpt_pkg::ST_OK;
          new_id      <= '0;
          wake        <= 1'b0;
          wake_task   <= '0;
          sleep_ticks <= '0;
        end
        S_MODIFY: begin
          state       <= S_IDLE;
          done        <= 1'b1;
          status      <= mod_status;
          new_id      <= '0;
          wake        <= mod_wake;
          wake_task   <= mod_wake_task;
          sleep_ticks <= mod_sleep;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `CPT_ASSERT_NEXT(a_no_result_after_accept, accept, !done, "result right after accept")
  `CPT_ASSERT_IMPL(a_count_bound, 1'b1, live_count <= CNT_MAX, "live count above table size")
  `CPT_ASSERT_IMPL(a_new_id_ok, done && new_id != '0, status == cpt_pkg::ST_OK,
                   "new id without success")
  `CPT_ASSERT_IMPL(a_wake_send, done && wake, status == cpt_pkg::ST_OK && op_q == cpt_pkg::OP_SEND,
                   "wake outside a successful send")
  `CPT_ASSERT_NEXT(a_close_shrinks, state == S_MOVE, live_count == $past(live_count) - CNT_W'(1),
                   "close did not shrink the table")

endmodule
